[rtl/calendar_clock_counter_assert.svh]
// Assertion macros for the calendar clock counter checker.
// Needs aclk and aresetn in scope at the point of use.
`ifndef CALENDAR_CLOCK_COUNTER_ASSERT_SVH
`define CALENDAR_CLOCK_COUNTER_ASSERT_SVH

// same-cycle implication
`define CCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ccc_pkg.sv]
// Package for the calendar clock counter: time record, flags, limits.
// Used by ccc_step and calendar_clock_counter; no dependencies.
package ccc_pkg;

    localparam int SEC_MAX   = 59;
    localparam int MIN_MAX   = 59;
    localparam int HOUR_MAX  = 23;
    localparam int MONTH_MAX = 12;
    localparam int YEAR_RST  = 70;

    localparam int TDATA_W   = 40;
    localparam int TIME_W    = 34;

    typedef enum logic [0:0] {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } func_t;

    // packed lowest field last: second sits in the low bits
    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } clk_time_t;

    typedef struct packed {
        logic minute_elapsed;
        logic second_elapsed;
    } ccc_flags_t;

    // last day of a month; months outside 1..12 use 31
    function automatic logic [4:0] month_limit(input logic [3:0] month, input logic leap);
        logic [4:0] lim;
        unique case (month)
            4'd2:                        lim = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     lim = 5'd30;
            default:                     lim = 5'd31;
        endcase
        return lim;
    endfunction

endpackage

[rtl/ccc_step.sv]
// Next-state logic of the calendar clock: one tick cascade or a load.
// Depends on ccc_pkg.
module ccc_step (
    input  ccc_pkg::clk_time_t  cur,
    input  logic                leap,
    input  ccc_pkg::func_t      func,
    input  ccc_pkg::clk_time_t  load,
    output ccc_pkg::clk_time_t  nxt,
    output logic                leap_nxt,
    output ccc_pkg::ccc_flags_t flags
);

    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [7:0] year_inc;
    logic       sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
    logic       c_min, c_hour, c_day, c_month, c_year;
    ccc_pkg::clk_time_t tick_time;

    assign sec_inc   = {1'b0, cur.second} + 7'd1;
    assign min_inc   = {1'b0, cur.minute} + 7'd1;
    assign hour_inc  = {1'b0, cur.hour} + 6'd1;
    assign day_inc   = {1'b0, cur.day} + 6'd1;
    assign month_inc = {1'b0, cur.month} + 5'd1;
    assign year_inc  = cur.year + 8'd1;

    assign sec_wrap   = sec_inc > 7'(ccc_pkg::SEC_MAX);
    assign min_wrap   = min_inc > 7'(ccc_pkg::MIN_MAX);
    assign hour_wrap  = hour_inc > 6'(ccc_pkg::HOUR_MAX);
    assign day_wrap   = day_inc > {1'b0, ccc_pkg::month_limit(cur.month, leap)};
    assign month_wrap = month_inc > 5'(ccc_pkg::MONTH_MAX);

    assign c_min   = sec_wrap;
    assign c_hour  = c_min & min_wrap;
    assign c_day   = c_hour & hour_wrap;
    assign c_month = c_day & day_wrap;
    assign c_year  = c_month & month_wrap;

    always_comb begin
        tick_time.second = sec_wrap ? 6'd0 : sec_inc[5:0];
        tick_time.minute = !c_min ? cur.minute : (min_wrap ? 6'd0 : min_inc[5:0]);
        tick_time.hour   = !c_hour ? cur.hour : (hour_wrap ? 5'd0 : hour_inc[4:0]);
        tick_time.day    = !c_day ? cur.day : (day_wrap ? 5'd1 : day_inc[4:0]);
        tick_time.month  = !c_month ? cur.month : (month_wrap ? 4'd1 : month_inc[3:0]);
        tick_time.year   = c_year ? year_inc : cur.year;
    end

    always_comb begin
        if (func == ccc_pkg::FUNC_LOAD) begin
            nxt                  = load;
            leap_nxt             = (load.year[1:0] == 2'd0);
            flags.second_elapsed = 1'b0;
            flags.minute_elapsed = 1'b0;
        end else begin
            nxt                  = tick_time;
            leap_nxt             = c_year ? (year_inc[1:0] == 2'd0) : leap;
            flags.second_elapsed = 1'b1;
            flags.minute_elapsed = c_min;
        end
    end

endmodule

[rtl/calendar_clock_counter.sv]
// Calendar clock counter top level: stream ports, time state, result register.
// Depends on ccc_pkg and ccc_step.
//
// Usage:
//   Each request on the s_ channel is a one-second tick (s_tuser = 0) or a
//   load of a full date and time (s_tuser = 1, fields in s_tdata). Every
//   request yields one result on the m_ channel: the time after the request
//   in m_tdata, with second and minute elapsed flags in m_tuser.
//   m_tvalid rises in the cycle after acceptance. While the receiver takes
//   results, a request can be taken every cycle; the single result register
//   sets this figure. If the receiver stalls, the result is held and s_tready
//   drops until the result is taken; s_tready stays high while the result
//   leaves that cycle. Reset (aresetn low, synchronous) sets 00:00:00 on day
//   1, month 1, year 70 (1970) with a 28-day February, and empties the result
//   register. Loaded values are stored as given, without range checks.
module calendar_clock_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] new_second, [11:6] new_minute, [16:12] new_hour, [21:17] new_day,
    // [25:22] new_month, [33:26] new_year, [39:34] zero
    input  logic [39:0] s_tdata,
    // [0] func
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] cur_second, [11:6] cur_minute, [16:12] cur_hour, [21:17] cur_day,
    // [25:22] cur_month, [33:26] cur_year, [39:34] zero
    output logic [39:0] m_tdata,
    // [0] second_elapsed, [1] minute_elapsed
    output logic [1:0]  m_tuser
);

    ccc_pkg::clk_time_t  time_reg, time_next;
    logic                leap_reg, leap_next;
    logic                m_tvalid_reg, m_tvalid_next;
    ccc_pkg::clk_time_t  m_time_reg;
    ccc_pkg::ccc_flags_t m_flags_reg, flags_next;
    logic                accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ccc_step u_step (
        .cur      (time_reg),
        .leap     (leap_reg),
        .func     (ccc_pkg::func_t'(s_tuser[0])),
        .load     (ccc_pkg::clk_time_t'(s_tdata[ccc_pkg::TIME_W-1:0])),
        .nxt      (time_next),
        .leap_nxt (leap_next),
        .flags    (flags_next)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg.second <= 6'd0;
            time_reg.minute <= 6'd0;
            time_reg.hour   <= 5'd0;
            time_reg.day    <= 5'd1;
            time_reg.month  <= 4'd1;
            time_reg.year   <= 8'(ccc_pkg::YEAR_RST);
            leap_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                time_reg <= time_next;
                leap_reg <= leap_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_time_reg  <= time_next;
            m_flags_reg <= flags_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(ccc_pkg::TDATA_W - ccc_pkg::TIME_W)'(0), m_time_reg};
    assign m_tuser  = m_flags_reg;

endmodule

[rtl/ccc_checker.sv]
// Port-level checker for calendar_clock_counter, bound to the top level.
// Depends on calendar_clock_counter_assert.svh.
`include "calendar_clock_counter_assert.svh"

module ccc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic s_accept;
    logic s_load;
    logic m_stall;
    logic min_flag;
    logic roll_ok;

    assign s_accept = s_tvalid && s_tready;
    assign s_load   = s_accept && s_tuser[0];
    assign m_stall  = m_tvalid && !m_tready;
    assign min_flag = m_tvalid && m_tuser[1];
    assign roll_ok  = m_tuser[0] && (m_tdata[5:0] == 6'd0);

    `CCC_ASSERT_NEXT(a_result_held, m_stall, m_tvalid && $stable(m_tdata), "result not held")
    `CCC_ASSERT_NEXT(a_request_gives_result, s_accept, m_tvalid, "request without result")
    `CCC_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "not ready with empty output")
    `CCC_ASSERT_NOW(a_minute_on_tick, min_flag, roll_ok, "minute flag without tick")
    `CCC_ASSERT_NEXT(a_load_no_flags, s_load, m_tuser == 2'b00, "flags set after load")

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
